/* rtl/core/strl_pkg.sv */
// Shared constants, types and the escape decode function of the string literal unescaper.
`timescale 1ns / 1ps

package strl_pkg;

    // Default size of the decoded buffer, terminator included.
    localparam int MAX_LEN_DEFAULT = 1024;

    localparam int CH_W  = 8;
    localparam int LEN_W = 12;

    // Parser phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;

    // Result kinds.
    localparam logic [1:0] K_BYTE = 2'd0;
    localparam logic [1:0] K_DONE = 2'd1;
    localparam logic [1:0] K_ERR  = 2'd2;

    // Error codes.
    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_NOQUOTE = 3'd1;
    localparam logic [2:0] E_NUL     = 3'd2;
    localparam logic [2:0] E_ESC     = 3'd3;
    localparam logic [2:0] E_OVER    = 3'd4;

    // Source characters with a meaning of their own.
    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CH_W-1:0]  byte_out;
        logic [2:0]       error_code;
        logic [LEN_W-1:0] token_length;
        logic             last;
    } strl_result_t;

    typedef struct packed {
        logic            ok;
        logic [CH_W-1:0] value;
    } strl_esc_t;

    // Maps the letter after a backslash to the byte it stands for.
    function automatic strl_esc_t decode_escape(input logic [CH_W-1:0] c);
        strl_esc_t r;
        r.ok = 1'b1;
        unique case (c)
            8'h6E:   r.value = 8'd10;  // n
            8'h74:   r.value = 8'd9;   // t
            8'h76:   r.value = 8'd11;  // v
            8'h62:   r.value = 8'd8;   // b
            8'h72:   r.value = 8'd13;  // r
            8'h66:   r.value = 8'd12;  // f
            8'h61:   r.value = 8'd7;   // a
            8'h5C:   r.value = 8'd92;  // backslash
            8'h3F:   r.value = 8'd63;  // question mark
            8'h22:   r.value = 8'd34;  // double quote
            8'h30:   r.value = 8'd0;   // zero
            default:
            begin
                r.ok    = 1'b0;
                r.value = 8'd0;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/strl_if.sv */
// Valid/ready channel interfaces for source bytes and decoded results.
`timescale 1ns / 1ps

interface strl_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] ch;

    modport source (output valid, output start_req, output ch, input ready);
    modport sink   (input valid, input start_req, input ch, output ready);
endinterface

interface strl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [2:0]  error_code;
    logic [11:0] token_length;
    logic        last;

    modport source (output valid, output kind, output byte_out, output error_code,
                    output token_length, output last, input ready);
    modport sink   (input valid, input kind, input byte_out, input error_code,
                    input token_length, input last, output ready);
endinterface

/* rtl/core/strl_step.sv */
// Parser state and the per-byte decode step of the string literal unescaper.
`timescale 1ns / 1ps

module strl_step #(
    parameter int MAX_LEN = strl_pkg::MAX_LEN_DEFAULT,
    parameter int WC_W    = $clog2(MAX_LEN + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      start_req,
    input  logic [strl_pkg::CH_W-1:0] ch,
    output logic                      has_res,
    output strl_pkg::strl_result_t    res,
    output logic [1:0]                phase,
    output logic [WC_W-1:0]           written_count
);

    logic [1:0]                 phase_reg, phase_next;
    logic [WC_W-1:0]            wc_reg, wc_next;
    logic [strl_pkg::LEN_W-1:0] cc_reg, cc_next;
    logic [strl_pkg::LEN_W-1:0] cc_inc;
    strl_pkg::strl_esc_t        esc;

    assign cc_inc        = cc_reg + 12'd1;
    assign esc           = strl_pkg::decode_escape(ch);
    assign phase         = phase_reg;
    assign written_count = wc_reg;

    always_comb
    begin
        phase_next = phase_reg;
        wc_next    = wc_reg;
        cc_next    = cc_reg;
        has_res    = 1'b0;
        res        = '0;

        if (start_req)
        begin
            wc_next = '0;
            cc_next = 12'd1;
            if (ch != strl_pkg::CH_QUOTE)
            begin
                phase_next     = strl_pkg::PH_IDLE;
                has_res        = 1'b1;
                res.kind       = strl_pkg::K_ERR;
                res.error_code = strl_pkg::E_NOQUOTE;
                res.last       = 1'b1;
            end
            else
            begin
                phase_next = strl_pkg::PH_BODY;
            end
        end
        else
        begin
            unique case (phase_reg)
                strl_pkg::PH_ESC:
                begin
                    cc_next = cc_inc;
                    has_res = 1'b1;
                    if (!esc.ok)
                    begin
                        phase_next     = strl_pkg::PH_IDLE;
                        res.kind       = strl_pkg::K_ERR;
                        res.error_code = strl_pkg::E_ESC;
                        res.last       = 1'b1;
                    end
                    else
                    begin
                        wc_next      = wc_reg + 1'b1;
                        phase_next   = strl_pkg::PH_BODY;
                        res.kind     = strl_pkg::K_BYTE;
                        res.byte_out = esc.value;
                    end
                end
                strl_pkg::PH_BODY:
                begin
                    cc_next = cc_inc;
                    if (wc_reg >= WC_W'(MAX_LEN))
                    begin
                        phase_next     = strl_pkg::PH_IDLE;
                        has_res        = 1'b1;
                        res.kind       = strl_pkg::K_ERR;
                        res.error_code = strl_pkg::E_OVER;
                        res.last       = 1'b1;
                    end
                    else if (ch == strl_pkg::CH_NUL)
                    begin
                        phase_next     = strl_pkg::PH_IDLE;
                        has_res        = 1'b1;
                        res.kind       = strl_pkg::K_ERR;
                        res.error_code = strl_pkg::E_NUL;
                        res.last       = 1'b1;
                    end
                    else if (ch == strl_pkg::CH_QUOTE)
                    begin
                        wc_next          = wc_reg + 1'b1;
                        phase_next       = strl_pkg::PH_IDLE;
                        has_res          = 1'b1;
                        res.kind         = strl_pkg::K_DONE;
                        res.token_length = cc_inc;
                        res.last         = 1'b1;
                    end
                    else if (ch == strl_pkg::CH_BSLASH)
                    begin
                        phase_next = strl_pkg::PH_ESC;
                    end
                    else
                    begin
                        wc_next      = wc_reg + 1'b1;
                        has_res      = 1'b1;
                        res.kind     = strl_pkg::K_BYTE;
                        res.byte_out = ch;
                    end
                end
                default:
                begin
                    // Bytes outside an attempt are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= strl_pkg::PH_IDLE;
            wc_reg    <= '0;
            cc_reg    <= '0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            wc_reg    <= wc_next;
            cc_reg    <= cc_next;
        end
    end

endmodule

/* rtl/core/strl_outreg.sv */
// Result register that drives the output channel.
`timescale 1ns / 1ps

module strl_outreg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  strl_pkg::strl_result_t res_in,
    output logic                   can_load,
    strl_out_if.source             res
);

    logic                   valid_reg, valid_next;
    strl_pkg::strl_result_t data_reg;

    // The register may be refilled when it is empty or being drained now.
    assign can_load   = !valid_reg || res.ready;
    assign valid_next = can_load ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            data_reg <= res_in;
        end
    end

    assign res.valid        = valid_reg;
    assign res.kind         = data_reg.kind;
    assign res.byte_out     = data_reg.byte_out;
    assign res.error_code   = data_reg.error_code;
    assign res.token_length = data_reg.token_length;
    assign res.last         = data_reg.last;

endmodule

/* rtl/core/string_literal_unescape.sv */
// Top level of the C string literal unescaper: input register, decode step, result register.
//
//   Channel | Direction | Payload                                         | Handshake
//   --------+-----------+-------------------------------------------------+------------
//   src     | in        | start_req, ch                                   | valid/ready
//   res     | out       | kind, byte_out, error_code, token_length, last  | valid/ready
//
// Each source byte is held in the input register, where the decode step updates
// the parser state and forms at most one result, and the result is registered
// in the output register; one byte is taken in every cycle while results drain.
// Reset (rst_n, asynchronous, active low) empties both registers and leaves the
// parser waiting for a request with start_req set.
// A byte that yields no result (opening quote, backslash, byte outside an attempt)
// moves on even while the result register is held by the sink. A byte that yields
// a result waits in the input register until the result register frees, and the
// source is then held off.
`timescale 1ns / 1ps

module string_literal_unescape #(
    parameter int MAX_LEN = strl_pkg::MAX_LEN_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    strl_in_if.sink    src,
    strl_out_if.source res
);

    localparam int WC_W = $clog2(MAX_LEN + 1);

    // Input register.
    logic                      in_v_reg, in_v_next;
    logic                      start_reg;
    logic [strl_pkg::CH_W-1:0] ch_reg;

    logic                   src_take;
    logic                   adv;
    logic                   has_res;
    logic                   can_load;
    strl_pkg::strl_result_t step_res;
    logic [1:0]             phase;
    logic [WC_W-1:0]        written_count;

    // The held request advances when it either needs no result slot or the
    // result register can take its result in this cycle.
    assign adv       = in_v_reg && (can_load || !has_res);
    assign src.ready = !in_v_reg || adv;
    assign src_take  = src.valid && src.ready;

    assign in_v_next = src_take ? 1'b1 : (adv ? 1'b0 : in_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            start_reg <= src.start_req;
            ch_reg    <= src.ch;
        end
    end

    // Parser state and the per-byte decision.
    strl_step #(
        .MAX_LEN (MAX_LEN),
        .WC_W    (WC_W)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .start_req     (start_reg),
        .ch            (ch_reg),
        .has_res       (has_res),
        .res           (step_res),
        .phase         (phase),
        .written_count (written_count)
    );

    // Result register toward the sink.
    strl_outreg u_outreg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv && has_res),
        .res_in   (step_res),
        .can_load (can_load),
        .res      (res)
    );

    // The decoded buffer never holds more than its size.
    a_written_bound: assert property (@(posedge clk) disable iff (!rst_n)
        written_count <= WC_W'(MAX_LEN))
        else $error("decoded byte count beyond buffer size");

    // A held request that cannot advance keeps its byte.
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && !adv) |=> (in_v_reg && $stable(ch_reg) && $stable(start_reg)))
        else $error("stalled request lost or changed");

    // The byte after a backslash always leaves the escape phase.
    a_escape_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && phase == strl_pkg::PH_ESC) |=> (phase != strl_pkg::PH_ESC))
        else $error("parser stuck after backslash");

    // Error results close the attempt and carry a cause.
    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == strl_pkg::K_ERR)
            |-> (res.last && res.error_code != strl_pkg::E_NONE))
        else $error("error result without cause or last flag");

endmodule

/* bench/string_literal_unescape_tb.sv */
// Self-checking testbench for the C string literal unescaper.
`timescale 1ns / 1ps

// The bench feeds source bytes through the input channel and checks every decoded
// result against a behavioral model of the parser that is kept inside the bench.
// A queue of pending requests is filled at time zero: first a few hand-picked
// literals, then one literal that fills the decoded buffer and overflows it, and
// then random requests until about 1250 requests are queued in all. The random
// requests are mostly well-formed literals with random bodies. The rest are
// broken literals, restarts and noise.
// The source pauses after each request and the sink after each result, for a
// random number of cycles, with quiet stretches in which neither side pauses.
module string_literal_unescape_tb;

    localparam int BUF_LEN    = strl_pkg::MAX_LEN_DEFAULT;
    localparam int TOTAL_REQS = 1250;
    localparam int MAX_PAUSE  = 17;
    localparam int REPORT_MAX = 10;

    // One source request: the start flag and the byte.
    typedef struct packed {
        logic       start;
        logic [7:0] ch;
    } src_req_t;

    logic clk;
    logic rst_n;

    strl_in_if  src_ch ();
    strl_out_if res_ch ();

    string_literal_unescape #(
        .MAX_LEN (BUF_LEN)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch),
        .res   (res_ch)
    );

    // The eleven letters that may follow a backslash.
    string esc_letters = "ntvbrfa\\?\"0";

    src_req_t               src_reqs[$];
    strl_pkg::strl_result_t due_results[$];
    src_req_t               next_req;
    strl_pkg::strl_result_t seen;
    strl_pkg::strl_result_t want;

    // Parser state of the behavioral model.
    logic [1:0] parse_phase  = strl_pkg::PH_IDLE;
    int         written_cnt  = 0;
    int         consumed_cnt = 0;

    int   mismatches = 0;
    int   src_wait   = 0;
    int   sink_wait  = 0;
    logic src_taken  = 1'b0;
    logic res_taken  = 1'b0;
    logic quiet      = 1'b0;

    always #5 clk = ~clk;

    // Maps the letter after a backslash to the byte it stands for; returns 0
    // when the letter is not a known escape.
    function automatic logic escape_value(input logic [7:0] c, output logic [7:0] v);
        escape_value = 1'b1;
        v            = 8'd0;
        case (c)
            "n":     v = 8'd10;
            "t":     v = 8'd9;
            "v":     v = 8'd11;
            "b":     v = 8'd8;
            "r":     v = 8'd13;
            "f":     v = 8'd12;
            "a":     v = 8'd7;
            "\\":    v = 8'd92;
            "?":     v = 8'd63;
            "\"":    v = 8'd34;
            "0":     v = 8'd0;
            default: escape_value = 1'b0;
        endcase
    endfunction

    // Advances the model by one accepted request and queues the result it gives,
    // if any.
    task automatic unescape_step(input logic start, input logic [7:0] c);
        strl_pkg::strl_result_t r;
        logic [7:0]             dec;
        logic                   emit;
        r      = '0;
        r.last = 1'b1;
        emit   = 1'b0;
        if (start)
        begin
            // A start always opens a fresh attempt, abandoning any open one.
            written_cnt  = 0;
            consumed_cnt = 1;
            if (c != strl_pkg::CH_QUOTE)
            begin
                parse_phase  = strl_pkg::PH_IDLE;
                r.kind       = strl_pkg::K_ERR;
                r.error_code = strl_pkg::E_NOQUOTE;
                emit         = 1'b1;
            end
            else
            begin
                parse_phase = strl_pkg::PH_BODY;
            end
        end
        else if (parse_phase == strl_pkg::PH_ESC)
        begin
            // The byte after a backslash is not checked against the buffer size.
            consumed_cnt++;
            if (!escape_value(c, dec))
            begin
                parse_phase  = strl_pkg::PH_IDLE;
                r.kind       = strl_pkg::K_ERR;
                r.error_code = strl_pkg::E_ESC;
            end
            else
            begin
                written_cnt++;
                parse_phase = strl_pkg::PH_BODY;
                r.kind      = strl_pkg::K_BYTE;
                r.byte_out  = dec;
                r.last      = 1'b0;
            end
            emit = 1'b1;
        end
        else if (parse_phase == strl_pkg::PH_BODY)
        begin
            consumed_cnt++;
            emit = 1'b1;
            if (written_cnt >= BUF_LEN)
            begin
                // A full buffer ends the attempt, whatever the byte is.
                parse_phase  = strl_pkg::PH_IDLE;
                r.kind       = strl_pkg::K_ERR;
                r.error_code = strl_pkg::E_OVER;
            end
            else if (c == strl_pkg::CH_NUL)
            begin
                parse_phase  = strl_pkg::PH_IDLE;
                r.kind       = strl_pkg::K_ERR;
                r.error_code = strl_pkg::E_NUL;
            end
            else if (c == strl_pkg::CH_QUOTE)
            begin
                // The terminator takes a place in the buffer too.
                written_cnt++;
                parse_phase    = strl_pkg::PH_IDLE;
                r.kind         = strl_pkg::K_DONE;
                r.token_length = consumed_cnt[strl_pkg::LEN_W-1:0];
            end
            else if (c == strl_pkg::CH_BSLASH)
            begin
                parse_phase = strl_pkg::PH_ESC;
                emit        = 1'b0;
            end
            else
            begin
                written_cnt++;
                r.kind     = strl_pkg::K_BYTE;
                r.byte_out = c;
                r.last     = 1'b0;
            end
        end
        if (emit)
            due_results.push_back(r);
    endtask

    // Pause length for one request; zero throughout a quiet stretch.
    function automatic int draw_pause();
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_PAUSE);
    endfunction

    // A body byte that is neither NUL, a quote nor a backslash.
    function automatic logic [7:0] draw_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == strl_pkg::CH_QUOTE || c == strl_pkg::CH_BSLASH);
        return c;
    endfunction

    task automatic push_req(input logic start, input logic [7:0] c);
        src_reqs.push_back({start, c});
    endtask

    // One random literal attempt. Most are well formed; the others break off in
    // one of the ways the parser has to catch.
    task automatic add_literal();
        int         ending;
        int         body_len;
        logic [7:0] c;
        logic [7:0] v;
        ending = $urandom_range(0, 99);
        if (ending < 6)
        begin
            do
                c = 8'($urandom);
            while (c == strl_pkg::CH_QUOTE);
            push_req(1'b1, c);
            return;
        end
        push_req(1'b1, strl_pkg::CH_QUOTE);
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
        repeat (body_len)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                push_req(1'b0, strl_pkg::CH_BSLASH);
                push_req(1'b0, esc_letters[$urandom_range(0, 10)]);
            end
            else
            begin
                push_req(1'b0, draw_plain());
            end
        end
        if (ending < 14)
        begin
            push_req(1'b0, strl_pkg::CH_NUL);
        end
        else if (ending < 22)
        begin
            // Any byte that is not an escape letter, NUL among them.
            do
                c = 8'($urandom);
            while (escape_value(c, v));
            push_req(1'b0, strl_pkg::CH_BSLASH);
            push_req(1'b0, c);
        end
        else if (ending < 28)
        begin
            // Left open: the next attempt restarts the parser in the body.
        end
        else if (ending < 32)
        begin
            // Left open right after a backslash.
            push_req(1'b0, strl_pkg::CH_BSLASH);
        end
        else if (ending < 38)
        begin
            repeat ($urandom_range(1, 4))
                push_req($urandom_range(0, 7) == 0, 8'($urandom));
        end
        else
        begin
            push_req(1'b0, strl_pkg::CH_QUOTE);
        end
        // Now and then a stray byte, ignored unless the attempt is still open.
        if ($urandom_range(0, 9) == 0)
            push_req(1'b0, 8'($urandom));
    endtask

    // Source side: a request is held until it is taken, and after each request
    // the source pauses for a random number of cycles.
    always @(negedge clk)
    begin
        if (rst_n && (!src_ch.valid || src_taken))
        begin
            if (src_wait > 0)
            begin
                src_wait--;
                src_ch.valid <= 1'b0;
            end
            else if (src_reqs.size() > 0)
            begin
                next_req = src_reqs.pop_front();
                src_ch.valid     <= 1'b1;
                src_ch.start_req <= next_req.start;
                src_ch.ch        <= next_req.ch;
                src_wait = draw_pause();
            end
            else
            begin
                src_ch.valid <= 1'b0;
            end
        end
    end

    // Result side: after each result taken, ready is held low for a random
    // number of cycles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
                sink_wait = draw_pause();
            if (sink_wait > 0)
            begin
                sink_wait--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Checks results and advances the model on each rising edge. The result is
    // checked before the request of the same edge is modeled, since that request
    // cannot produce a result yet.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            src_taken <= 1'b0;
            res_taken <= 1'b0;
        end
        else
        begin
            src_taken <= src_ch.valid && src_ch.ready;
            res_taken <= res_ch.valid && res_ch.ready;
            if ($urandom_range(0, 199) == 0)
                quiet <= !quiet;

            if (res_ch.valid && res_ch.ready)
            begin
                seen.kind         = res_ch.kind;
                seen.byte_out     = res_ch.byte_out;
                seen.error_code   = res_ch.error_code;
                seen.token_length = res_ch.token_length;
                seen.last         = res_ch.last;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with none expected: kind %0d byte %h err %0d",
                                 $realtime, seen.kind, seen.byte_out, seen.error_code);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (seen.kind !== want.kind || seen.byte_out !== want.byte_out
                        || seen.error_code !== want.error_code
                        || seen.token_length !== want.token_length
                        || seen.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch (expected/actual) kind %0d/%0d byte %h/%h",
                                     $realtime, want.kind, seen.kind,
                                     want.byte_out, seen.byte_out);
                            $display("    err %0d/%0d len %0d/%0d last %0b/%0b",
                                     want.error_code, seen.error_code,
                                     want.token_length, seen.token_length,
                                     want.last, seen.last);
                        end
                    end
                end
            end

            if (src_ch.valid && src_ch.ready)
                unescape_step(src_ch.start_req, src_ch.ch);
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        src_ch.valid     = 1'b0;
        src_ch.start_req = 1'b0;
        src_ch.ch        = 8'd0;
        res_ch.ready     = 1'b0;

        // Hand-picked cases. A byte outside any attempt is dropped silently, and
        // an attempt that does not open with a quote fails at once.
        push_req(1'b0, "A");
        push_req(1'b1, "A");
        // Every escape letter in one literal.
        push_req(1'b1, strl_pkg::CH_QUOTE);
        for (int i = 0; i < 11; i++)
        begin
            push_req(1'b0, strl_pkg::CH_BSLASH);
            push_req(1'b0, esc_letters[i]);
        end
        push_req(1'b0, strl_pkg::CH_QUOTE);
        // NUL in the body.
        push_req(1'b1, strl_pkg::CH_QUOTE);
        push_req(1'b0, strl_pkg::CH_NUL);
        // NUL after a backslash is a bad escape.
        push_req(1'b1, strl_pkg::CH_QUOTE);
        push_req(1'b0, strl_pkg::CH_BSLASH);
        push_req(1'b0, strl_pkg::CH_NUL);
        // A restart in the body, followed by the empty literal.
        push_req(1'b1, strl_pkg::CH_QUOTE);
        push_req(1'b0, 8'hFF);
        push_req(1'b1, strl_pkg::CH_QUOTE);
        push_req(1'b0, strl_pkg::CH_QUOTE);

        // Plain bytes up to one short of full, an escape that fills the buffer,
        // then one more body byte, which must overflow.
        push_req(1'b1, strl_pkg::CH_QUOTE);
        for (int i = 0; i < BUF_LEN - 1; i++)
            push_req(1'b0, draw_plain());
        push_req(1'b0, strl_pkg::CH_BSLASH);
        push_req(1'b0, "n");
        push_req(1'b0, 8'($urandom));

        while (src_reqs.size() < TOTAL_REQS)
            add_literal();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every result to arrive, then
        // give the block time to show any result that should not come.
        while (src_reqs.size() > 0 || src_ch.valid)
            @(negedge clk);
        while (due_results.size() > 0)
            @(negedge clk);
        repeat (4 * MAX_PAUSE) @(negedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Guard against a hang: far longer than the slowest correct run.
    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
